### rtl/qefm_pkg.sv
// Shared constants and types of the quantized elementwise fmod unit.
`default_nettype none

package qefm_pkg;

    // Fixed field widths of the channels
    localparam int FIELD_BITS   = 16;
    localparam int EXP_BITS     = 5;
    localparam int CFG_IDX_BITS = 2;

    // Alignment shift runs 0..31 (exponents -16..15)
    localparam int SHIFT_BITS = 5;
    localparam int MAX_ALIGN  = 31;

    // Output rescale amount, minimum exponent minus output exponent, -31..31
    localparam int SCALE_BITS = 6;

    // Width of the narrow saturation range
    localparam int NARROW_BITS = 8;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_DIVIDEND_EXP = 2'd0,
        REG_DIVISOR_EXP  = 2'd1,
        REG_OUTPUT_EXP   = 2'd2,
        REG_NARROW       = 2'd3
    } cfg_reg_t;

    // Per-item control that travels with the remainder through the cells
    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic                  neg;
        logic                  zero;
        logic [SHIFT_BITS-1:0] shift;
    } lane_ctrl_t;

endpackage

`default_nettype wire

### rtl/qefm_if.sv
// Channel interfaces of the quantized elementwise fmod unit.
`default_nettype none

// Operand channel: one dividend/divisor pair per transaction
interface qefm_item_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [qefm_pkg::FIELD_BITS-1:0] dividend;
    logic signed [qefm_pkg::FIELD_BITS-1:0] divisor;
    logic                                  last_in;

    modport source (output valid, output dividend, output divisor, output last_in, input ready);
    modport sink   (input valid, input dividend, input divisor, input last_in, output ready);
endinterface

// Result channel: one remainder per transaction
interface qefm_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [qefm_pkg::FIELD_BITS-1:0] remainder_out;
    logic                                  last_out;

    modport source (output valid, output remainder_out, output last_out, input ready);
    modport sink   (input valid, input remainder_out, input last_out, output ready);
endinterface

// Configuration write channel
interface qefm_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [qefm_pkg::CFG_IDX_BITS-1:0]      index;
    logic [qefm_pkg::EXP_BITS-1:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/quantized_elementwise_fmod_unit.sv
// Top level of the quantized elementwise truncated-remainder (fmod) unit.
// Usage:
//   operand: one dividend/divisor pair per transaction, last_in marks row end.
//   result:  one remainder per operand transaction, in order, last_out copied.
//   cfg:     register writes (0 dividend exp, 1 divisor exp, 2 output exp,
//            3 narrow saturation); always ready, write only while idle.
// Stages from operand to result, in order:
//   one align stage, DATA_BITS + 31 division cells, two rescale stages and
//   the output register. The cell chain retires one quotient bit per cell.
// Throughput: one item per cycle, every cycle, while the result side takes.
// Reset: all pipeline valid bits and the output buffer clear; registers go
//   to zero (int16 saturation, unit scales).
// Stall: an output register plus a one-entry skid buffer catch the item in
//   flight; operand.ready drops as soon as the skid fills and the whole
//   chain holds until the result side takes again.
`default_nettype none

module quantized_elementwise_fmod_unit #(
    parameter int DATA_BITS = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    qefm_cfg_if.sink       cfg,
    qefm_item_if.sink      operand,
    qefm_result_if.source  result
);

    localparam int NUM_BITS = DATA_BITS + qefm_pkg::MAX_ALIGN;

    // Configuration registers
    logic signed [qefm_pkg::EXP_BITS-1:0] dividend_exp_reg;
    logic signed [qefm_pkg::EXP_BITS-1:0] divisor_exp_reg;
    logic signed [qefm_pkg::EXP_BITS-1:0] output_exp_reg;
    logic                                 narrow_reg;

    logic signed [qefm_pkg::EXP_BITS-1:0]   min_exp;
    logic signed [qefm_pkg::SCALE_BITS-1:0] scale;

    // Cell chain
    qefm_pkg::lane_ctrl_t chain_ctrl [0:NUM_BITS];
    logic [NUM_BITS-1:0]  chain_num  [0:NUM_BITS];
    logic [DATA_BITS-1:0] chain_div  [0:NUM_BITS];
    logic [DATA_BITS-1:0] chain_rem  [0:NUM_BITS];
    logic [DATA_BITS-1:0] chain_low  [0:NUM_BITS];

    logic                            advance;
    logic                            res_valid;
    logic                            res_last;
    logic [qefm_pkg::FIELD_BITS-1:0] res_value;
    logic                            push;

    // Output register and skid buffer
    logic                            out_v_reg;
    logic                            out_last_reg;
    logic [qefm_pkg::FIELD_BITS-1:0] out_data_reg;
    logic                            skid_v_reg;
    logic                            skid_last_reg;
    logic [qefm_pkg::FIELD_BITS-1:0] skid_data_reg;

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dividend_exp_reg <= '0;
            divisor_exp_reg  <= '0;
            output_exp_reg   <= '0;
            narrow_reg       <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (qefm_pkg::cfg_reg_t'(cfg.index))
                qefm_pkg::REG_DIVIDEND_EXP: dividend_exp_reg <= cfg.data;
                qefm_pkg::REG_DIVISOR_EXP:  divisor_exp_reg  <= cfg.data;
                qefm_pkg::REG_OUTPUT_EXP:   output_exp_reg   <= cfg.data;
                qefm_pkg::REG_NARROW:       narrow_reg       <= cfg.data[0];
                default:                    narrow_reg       <= narrow_reg;
            endcase
        end
    end

    // Rescale amount: smaller input exponent minus output exponent
    always_comb
    begin
        min_exp = (dividend_exp_reg < divisor_exp_reg) ? dividend_exp_reg : divisor_exp_reg;
        scale   = qefm_pkg::SCALE_BITS'(min_exp) - qefm_pkg::SCALE_BITS'(output_exp_reg);
    end

    // Whole pipeline moves while the skid entry is free
    assign advance       = !skid_v_reg;
    assign operand.ready = advance;

    qefm_front #(
        .DATA_BITS (DATA_BITS),
        .NUM_BITS  (NUM_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (advance),
        .valid        (operand.valid),
        .dividend     (operand.dividend),
        .divisor      (operand.divisor),
        .last         (operand.last_in),
        .dividend_exp (dividend_exp_reg),
        .divisor_exp  (divisor_exp_reg),
        .ctrl_o       (chain_ctrl[0]),
        .num_o        (chain_num[0]),
        .div_o        (chain_div[0]),
        .low_o        (chain_low[0])
    );

    assign chain_rem[0] = '0;

    // One division cell per bit of the aligned dividend
    for (genvar i = 0; i < NUM_BITS; i++)
    begin : g_cell
        qefm_cell #(
            .DATA_BITS (DATA_BITS),
            .NUM_BITS  (NUM_BITS)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (advance),
            .ctrl_i (chain_ctrl[i]),
            .num_i  (chain_num[i]),
            .div_i  (chain_div[i]),
            .rem_i  (chain_rem[i]),
            .low_i  (chain_low[i]),
            .ctrl_o (chain_ctrl[i+1]),
            .num_o  (chain_num[i+1]),
            .div_o  (chain_div[i+1]),
            .rem_o  (chain_rem[i+1]),
            .low_o  (chain_low[i+1])
        );
    end

    qefm_rescale #(
        .DATA_BITS (DATA_BITS),
        .NUM_BITS  (NUM_BITS)
    ) u_rescale (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (advance),
        .ctrl_i  (chain_ctrl[NUM_BITS]),
        .rem_i   (chain_rem[NUM_BITS]),
        .low_i   (chain_low[NUM_BITS]),
        .scale   (scale),
        .narrow  (narrow_reg),
        .valid_o (res_valid),
        .last_o  (res_last),
        .value_o (res_value)
    );

    // The final chain item transfers out only on a moving cycle
    assign push = res_valid && advance;

    // Output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (result.ready)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
        end
        else if (!out_v_reg || result.ready)
        begin
            out_v_reg <= push;
        end
        else if (push)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (result.ready)
            begin
                out_data_reg <= skid_data_reg;
                out_last_reg <= skid_last_reg;
            end
        end
        else if (!out_v_reg || result.ready)
        begin
            out_data_reg <= res_value;
            out_last_reg <= res_last;
        end
        else if (push)
        begin
            skid_data_reg <= res_value;
            skid_last_reg <= res_last;
        end
    end

    assign result.valid         = out_v_reg;
    assign result.remainder_out = out_data_reg;
    assign result.last_out      = out_last_reg;

`ifndef NO_ASSERTIONS
    // The skid entry is only ever occupied behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry full with empty output register");

    // The skid entry fills only when the output was stalled
    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_v_reg && !result.ready))
        else $error("skid entry filled without an output stall");

    // Narrow mode results stay inside the int8 range
    a_narrow_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && narrow_reg) |->
            ((result.remainder_out[qefm_pkg::FIELD_BITS-1:qefm_pkg::NARROW_BITS-1] == '0) ||
             (result.remainder_out[qefm_pkg::FIELD_BITS-1:qefm_pkg::NARROW_BITS-1] == '1)))
        else $error("narrow result outside int8 range");
`endif

endmodule

`default_nettype wire

### rtl/qefm_front.sv
// Input stage: operand magnitudes and exponent alignment of the dividend.
`default_nettype none

module qefm_front #(
    parameter int DATA_BITS = 16,
    parameter int NUM_BITS  = 47
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 en,
    input  wire logic                                 valid,
    input  wire logic [qefm_pkg::FIELD_BITS-1:0]      dividend,
    input  wire logic [qefm_pkg::FIELD_BITS-1:0]      divisor,
    input  wire logic                                 last,
    input  wire logic signed [qefm_pkg::EXP_BITS-1:0] dividend_exp,
    input  wire logic signed [qefm_pkg::EXP_BITS-1:0] divisor_exp,
    output qefm_pkg::lane_ctrl_t                      ctrl_o,
    output logic [NUM_BITS-1:0]                       num_o,
    output logic [DATA_BITS-1:0]                      div_o,
    output logic [DATA_BITS-1:0]                      low_o
);

    logic [DATA_BITS-1:0]                   x_bits;
    logic [DATA_BITS-1:0]                   y_bits;
    logic [DATA_BITS-1:0]                   a_mag;
    logic [DATA_BITS-1:0]                   b_mag;
    logic signed [qefm_pkg::SCALE_BITS-1:0] diff;
    logic signed [qefm_pkg::SCALE_BITS-1:0] neg_diff;
    logic                                   up_align;
    logic [qefm_pkg::SHIFT_BITS-1:0]        align;
    logic [NUM_BITS-1:0]                    a_wide;
    logic [DATA_BITS-1:0]                   low_mask;

    qefm_pkg::lane_ctrl_t ctrl_reg, ctrl_next;
    logic [NUM_BITS-1:0]  num_reg, num_next;
    logic [DATA_BITS-1:0] div_reg, div_next;
    logic [DATA_BITS-1:0] low_reg, low_next;

    // Magnitudes of the sign-extended low DATA_BITS bits
    always_comb
    begin
        x_bits = dividend[DATA_BITS-1:0];
        y_bits = divisor[DATA_BITS-1:0];
        a_mag  = x_bits[DATA_BITS-1] ? (~x_bits + 1'b1) : x_bits;
        b_mag  = y_bits[DATA_BITS-1] ? (~y_bits + 1'b1) : y_bits;
    end

    // Align to the smaller exponent. Dividend larger: shift the dividend up.
    // Divisor larger: divide the high part and rebuild with the low bits later.
    always_comb
    begin
        diff     = qefm_pkg::SCALE_BITS'(dividend_exp) - qefm_pkg::SCALE_BITS'(divisor_exp);
        neg_diff = -diff;
        up_align = !diff[qefm_pkg::SCALE_BITS-1];
        align    = up_align ? diff[qefm_pkg::SHIFT_BITS-1:0]
                            : neg_diff[qefm_pkg::SHIFT_BITS-1:0];
        a_wide   = NUM_BITS'(a_mag);
        low_mask = ~({DATA_BITS{1'b1}} << align);

        num_next = up_align ? (a_wide << align) : (a_wide >> align);
        low_next = up_align ? '0 : (a_mag & low_mask);
        div_next = b_mag;

        ctrl_next.valid = valid;
        ctrl_next.last  = last;
        ctrl_next.neg   = x_bits[DATA_BITS-1];
        ctrl_next.zero  = (b_mag == '0);
        ctrl_next.shift = up_align ? '0 : align;
    end

    // Control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_next;
            div_reg <= div_next;
            low_reg <= low_next;
        end
    end

    assign ctrl_o = ctrl_reg;
    assign num_o  = num_reg;
    assign div_o  = div_reg;
    assign low_o  = low_reg;

endmodule

`default_nettype wire

### rtl/qefm_cell.sv
// One restoring-division cell: takes one dividend bit, holds one partial remainder.
`default_nettype none

module qefm_cell #(
    parameter int DATA_BITS = 16,
    parameter int NUM_BITS  = 47
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire qefm_pkg::lane_ctrl_t ctrl_i,
    input  wire logic [NUM_BITS-1:0]  num_i,
    input  wire logic [DATA_BITS-1:0] div_i,
    input  wire logic [DATA_BITS-1:0] rem_i,
    input  wire logic [DATA_BITS-1:0] low_i,
    output qefm_pkg::lane_ctrl_t      ctrl_o,
    output logic [NUM_BITS-1:0]       num_o,
    output logic [DATA_BITS-1:0]      div_o,
    output logic [DATA_BITS-1:0]      rem_o,
    output logic [DATA_BITS-1:0]      low_o
);

    logic [DATA_BITS-1:0] trial;
    logic                 fits;

    qefm_pkg::lane_ctrl_t ctrl_reg;
    logic [NUM_BITS-1:0]  num_reg, num_next;
    logic [DATA_BITS-1:0] div_reg;
    logic [DATA_BITS-1:0] rem_reg, rem_next;
    logic [DATA_BITS-1:0] low_reg;

    // Shift in the next dividend bit, subtract the divisor when it fits
    always_comb
    begin
        trial    = {rem_i[DATA_BITS-2:0], num_i[NUM_BITS-1]};
        fits     = (trial >= div_i);
        rem_next = fits ? (trial - div_i) : trial;
        num_next = num_i << 1;
    end

    // Control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl_i;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_next;
            div_reg <= div_i;
            rem_reg <= rem_next;
            low_reg <= low_i;
        end
    end

    assign ctrl_o = ctrl_reg;
    assign num_o  = num_reg;
    assign div_o  = div_reg;
    assign rem_o  = rem_reg;
    assign low_o  = low_reg;

endmodule

`default_nettype wire

### rtl/qefm_rescale.sv
// Remainder rebuild, power-of-two rescale with round-half-even, and saturation.
`default_nettype none

module qefm_rescale #(
    parameter int DATA_BITS = 16,
    parameter int NUM_BITS  = 47
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   en,
    input  wire qefm_pkg::lane_ctrl_t                   ctrl_i,
    input  wire logic [DATA_BITS-1:0]                   rem_i,
    input  wire logic [DATA_BITS-1:0]                   low_i,
    input  wire logic signed [qefm_pkg::SCALE_BITS-1:0] scale,
    input  wire logic                                   narrow,
    output logic                                        valid_o,
    output logic                                        last_o,
    output logic [qefm_pkg::FIELD_BITS-1:0]             value_o
);

    localparam logic [DATA_BITS-1:0] WIDE_NEG = {1'b1, {(DATA_BITS-1){1'b0}}};
    localparam logic [DATA_BITS-1:0] WIDE_POS = {1'b0, {(DATA_BITS-1){1'b1}}};
    localparam logic [DATA_BITS-1:0] NAR_NEG  = DATA_BITS'(1) << (qefm_pkg::NARROW_BITS - 1);
    localparam logic [DATA_BITS-1:0] NAR_POS  = NAR_NEG - 1'b1;

    // Saturation bound on the magnitude for the given sign
    function automatic logic [DATA_BITS-1:0] limit_of(input logic neg, input logic nar);
        logic [DATA_BITS-1:0] lim;
        if (nar)
        begin
            lim = neg ? NAR_NEG : NAR_POS;
        end
        else
        begin
            lim = neg ? WIDE_NEG : WIDE_POS;
        end
        return lim;
    endfunction

    // Stage 1 signals
    logic [NUM_BITS-1:0]  r_next;
    qefm_pkg::lane_ctrl_t s1_ctrl_reg;
    logic [NUM_BITS-1:0]  s1_r_reg;

    // Stage 2 signals
    logic signed [qefm_pkg::SCALE_BITS-1:0] neg_scale;
    logic [qefm_pkg::SHIFT_BITS-1:0]        sh_up;
    logic [qefm_pkg::SHIFT_BITS-1:0]        sh_dn;
    logic [qefm_pkg::SHIFT_BITS-1:0]        sh_half;
    logic [DATA_BITS-1:0]                   lim1;
    logic [DATA_BITS-1:0]                   cap;
    logic [NUM_BITS-1:0]                    half_word;
    logic                                   sticky;
    logic                                   up_next;
    logic                                   over_next;
    logic [DATA_BITS-1:0]                   up_val_next;
    logic [NUM_BITS-1:0]                    q_next;
    logic                                   rnd_next;

    qefm_pkg::lane_ctrl_t s2_ctrl_reg;
    logic                 s2_up_reg;
    logic                 s2_over_reg;
    logic [DATA_BITS-1:0] s2_up_val_reg;
    logic [NUM_BITS-1:0]  s2_q_reg;
    logic                 s2_rnd_reg;

    // Output step signals
    logic [DATA_BITS-1:0]            lim2;
    logic [NUM_BITS-1:0]             q_round;
    logic [DATA_BITS-1:0]            mag;
    logic [qefm_pkg::FIELD_BITS-1:0] mag_ext;

    // Stage 1: rebuild the exact remainder; zero divisor gives zero
    always_comb
    begin
        r_next = (NUM_BITS'(rem_i) << ctrl_i.shift) | NUM_BITS'(low_i);
        if (ctrl_i.zero)
        begin
            r_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
        end
        else if (en)
        begin
            s1_ctrl_reg <= ctrl_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_r_reg <= r_next;
        end
    end

    // Stage 2: up-shift with overflow check, or down-shift with rounding bits
    always_comb
    begin
        neg_scale   = -scale;
        up_next     = !scale[qefm_pkg::SCALE_BITS-1];
        sh_up       = scale[qefm_pkg::SHIFT_BITS-1:0];
        sh_dn       = neg_scale[qefm_pkg::SHIFT_BITS-1:0];
        sh_half     = sh_dn - 1'b1;
        lim1        = limit_of(s1_ctrl_reg.neg, narrow);
        cap         = lim1 >> sh_up;
        over_next   = (s1_r_reg > NUM_BITS'(cap));
        up_val_next = s1_r_reg[DATA_BITS-1:0] << sh_up;
        q_next      = s1_r_reg >> sh_dn;
        half_word   = s1_r_reg >> sh_half;
        sticky      = |(s1_r_reg & ~({NUM_BITS{1'b1}} << sh_half));
        rnd_next    = half_word[0] && (sticky || q_next[0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctrl_reg <= '0;
        end
        else if (en)
        begin
            s2_ctrl_reg <= s1_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_up_reg     <= up_next;
            s2_over_reg   <= over_next;
            s2_up_val_reg <= up_val_next;
            s2_q_reg      <= q_next;
            s2_rnd_reg    <= rnd_next;
        end
    end

    // Output step: round increment, saturate, apply the dividend sign
    always_comb
    begin
        lim2    = limit_of(s2_ctrl_reg.neg, narrow);
        q_round = s2_q_reg + NUM_BITS'(s2_rnd_reg);
        if (s2_up_reg)
        begin
            mag = s2_over_reg ? lim2 : s2_up_val_reg;
        end
        else
        begin
            mag = (q_round > NUM_BITS'(lim2)) ? lim2 : q_round[DATA_BITS-1:0];
        end
        mag_ext = qefm_pkg::FIELD_BITS'(mag);
        value_o = s2_ctrl_reg.neg ? (~mag_ext + 1'b1) : mag_ext;
    end

    assign valid_o = s2_ctrl_reg.valid;
    assign last_o  = s2_ctrl_reg.last;

endmodule

`default_nettype wire

### sim/quantized_elementwise_fmod_unit_tb.sv
// Self-checking testbench for the quantized elementwise fmod unit.
`default_nettype none

module quantized_elementwise_fmod_unit_tb;

    localparam int DATA_BITS        = 16;
    localparam int LATENCY          = DATA_BITS + 35;
    localparam int PHASE_ITEMS      = 104;
    localparam int RANDOM_PHASES    = 8;
    localparam int LONG_HOLD_AT     = 132;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT      = 200000;

    typedef struct packed {
        logic signed [qefm_pkg::FIELD_BITS-1:0] dividend;
        logic signed [qefm_pkg::FIELD_BITS-1:0] divisor;
        logic                                   last;
    } operand_t;

    typedef struct packed {
        logic [qefm_pkg::FIELD_BITS-1:0] remainder;
        logic                            last;
    } remainder_t;

    logic clk = 1'b0;
    logic rst_n;

    qefm_cfg_if    cfg_bus();
    qefm_item_if   operand_bus();
    qefm_result_if result_bus();

    quantized_elementwise_fmod_unit #(
        .DATA_BITS (DATA_BITS)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .operand (operand_bus),
        .result  (result_bus)
    );

    // Shadow copy of the scale and saturation registers
    logic signed [qefm_pkg::EXP_BITS-1:0] dividend_exp_reg;
    logic signed [qefm_pkg::EXP_BITS-1:0] divisor_exp_reg;
    logic signed [qefm_pkg::EXP_BITS-1:0] output_exp_reg;
    logic                                 narrow_reg;

    operand_t   pending_ops[$];
    remainder_t remainder_queue[$];
    operand_t   offered_op;
    int         src_gap;
    int         sink_gap;
    int         hold_left;
    int         results_seen;
    int         fail_count;
    int         cycle_count;
    bit         idle_enable;

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Aligned truncated remainder, rescaled, rounded half-even and saturated
    function automatic remainder_t predict_remainder(operand_t op);
        int         x;
        int         y;
        int         de;
        int         ve;
        int         m;
        int         s;
        int         k;
        int         obits;
        bit         neg;
        logic [63:0] amag;
        logic [63:0] bmag;
        logic [63:0] r;
        logic [63:0] lim;
        logic [63:0] cap;
        logic [63:0] q;
        logic [63:0] frac;
        logic [63:0] half;
        logic [63:0] mag;
        remainder_t  res;
        x   = int'(op.dividend);
        y   = int'(op.divisor);
        de  = int'(dividend_exp_reg);
        ve  = int'(divisor_exp_reg);
        neg = (x < 0);
        m   = (de < ve) ? de : ve;
        amag = (x < 0) ? 64'(-x) : 64'(x);
        bmag = (y < 0) ? 64'(-y) : 64'(y);
        amag = amag << (de - m);
        bmag = bmag << (ve - m);
        r    = (bmag != 64'd0) ? (amag % bmag) : 64'd0;
        s     = m - int'(output_exp_reg);
        obits = narrow_reg ? qefm_pkg::NARROW_BITS : DATA_BITS;
        lim   = neg ? (64'd1 << (obits - 1)) : ((64'd1 << (obits - 1)) - 64'd1);
        if (s >= 0)
        begin
            cap = lim >> s;
            mag = (r > cap) ? lim : (r << s);
        end
        else
        begin
            k    = -s;
            q    = r >> k;
            frac = r & ((64'd1 << k) - 64'd1);
            half = 64'd1 << (k - 1);
            if (frac > half || (frac == half && q[0]))
                q = q + 64'd1;
            mag = (q > lim) ? lim : q;
        end
        res.remainder = neg ? (~mag[qefm_pkg::FIELD_BITS-1:0] + 1'b1)
                            : mag[qefm_pkg::FIELD_BITS-1:0];
        res.last      = op.last;
        return res;
    endfunction

    // Operand values: full range in half the draws, else extremes and small magnitudes
    function automatic logic [qefm_pkg::FIELD_BITS-1:0] random_operand_value(bit allow_zero);
        logic [qefm_pkg::FIELD_BITS-1:0] v;
        case ($urandom_range(0, 11))
            0:       v = 16'h8000;
            1:       v = 16'h7FFF;
            2:       v = 16'($urandom_range(0, 4) - 2);
            3, 4:    v = 16'($urandom_range(0, 63) - 32);
            5:       v = 16'($urandom_range(0, 2047) - 1024);
            default: v = 16'($urandom);
        endcase
        if (allow_zero && $urandom_range(0, 11) == 0)
            v = '0;
        return v;
    endfunction

    function automatic operand_t random_operand();
        operand_t op;
        op.dividend = random_operand_value(1'b0);
        op.divisor  = random_operand_value(1'b1);
        op.last     = ($urandom_range(0, 3) == 0);
        return op;
    endfunction

    function automatic int random_exponent();
        return $urandom_range(0, 31) - 16;
    endfunction

    // Operand driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operand_bus.valid <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (operand_bus.valid && operand_bus.ready)
                remainder_queue.push_back(predict_remainder(offered_op));
            if (!operand_bus.valid || operand_bus.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    operand_bus.valid <= 1'b0;
                end
                else if (pending_ops.size() > 0)
                begin
                    offered_op = pending_ops.pop_front();
                    operand_bus.dividend <= offered_op.dividend;
                    operand_bus.divisor  <= offered_op.divisor;
                    operand_bus.last_in  <= offered_op.last;
                    operand_bus.valid    <= 1'b1;
                    if (idle_enable && $urandom_range(0, 7) == 0)
                        src_gap = $urandom_range(1, 6);
                end
                else
                begin
                    operand_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and ready generation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            sink_gap     = 0;
            hold_left    = 0;
            results_seen = 0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                results_seen++;
                if (remainder_queue.size() == 0)
                begin
                    $error("result transaction with no expectation: remainder_out %0d",
                           $signed(result_bus.remainder_out));
                    fail_count++;
                end
                else
                begin
                    remainder_t exp_res;
                    exp_res = remainder_queue.pop_front();
                    if (result_bus.remainder_out !== exp_res.remainder)
                    begin
                        $error("remainder_out: expected %0d, actual %0d",
                               $signed(exp_res.remainder), $signed(result_bus.remainder_out));
                        fail_count++;
                    end
                    if (result_bus.last_out !== exp_res.last)
                    begin
                        $error("last_out: expected %0d, actual %0d",
                               exp_res.last, result_bus.last_out);
                        fail_count++;
                    end
                end
                // one long hold-off so the pipeline fills and stalls its input
                if (results_seen == LONG_HOLD_AT)
                    hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= 1'b1;
                if (idle_enable && $urandom_range(0, 9) == 0)
                    sink_gap = $urandom_range(1, 6);
            end
        end
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Wait until every offered operand has come back as a result
    task automatic wait_drained();
        while (pending_ops.size() != 0 || operand_bus.valid || remainder_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(qefm_pkg::cfg_reg_t idx, logic [qefm_pkg::EXP_BITS-1:0] value);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (idx)
            qefm_pkg::REG_DIVIDEND_EXP: dividend_exp_reg = value;
            qefm_pkg::REG_DIVISOR_EXP:  divisor_exp_reg  = value;
            qefm_pkg::REG_OUTPUT_EXP:   output_exp_reg   = value;
            qefm_pkg::REG_NARROW:       narrow_reg       = value[0];
            default:                    ;
        endcase
    endtask

    task automatic set_config(int de, int ve, int oe, bit narrow);
        write_reg(qefm_pkg::REG_DIVIDEND_EXP, qefm_pkg::EXP_BITS'(de));
        write_reg(qefm_pkg::REG_DIVISOR_EXP, qefm_pkg::EXP_BITS'(ve));
        write_reg(qefm_pkg::REG_OUTPUT_EXP, qefm_pkg::EXP_BITS'(oe));
        write_reg(qefm_pkg::REG_NARROW, {{(qefm_pkg::EXP_BITS-1){1'b0}}, narrow});
    endtask

    task automatic add_op(int dividend, int divisor, bit last);
        operand_t op;
        op.dividend = qefm_pkg::FIELD_BITS'(dividend);
        op.divisor  = qefm_pkg::FIELD_BITS'(divisor);
        op.last     = last;
        pending_ops.push_back(op);
    endtask

    // Stimulus sequence
    initial
    begin
        int de;
        int ve;
        int oe;
        int m;
        operand_bus.valid    = 1'b0;
        operand_bus.dividend = '0;
        operand_bus.divisor  = '0;
        operand_bus.last_in  = 1'b0;
        result_bus.ready     = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = '0;
        cfg_bus.data         = '0;
        dividend_exp_reg     = '0;
        divisor_exp_reg      = '0;
        output_exp_reg       = '0;
        narrow_reg           = 1'b0;
        fail_count           = 0;
        idle_enable          = 1'b1;
        rst_n                = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: extremes, zero divisor, negative zero
        add_op(0, 5, 0);
        add_op(7, 0, 1);
        add_op(-32768, 3, 0);
        add_op(32767, -32768, 0);
        add_op(-32768, -32768, 1);
        add_op(-32768, -1, 0);
        add_op(-7, 2, 0);
        add_op(-4, 2, 1);
        add_op(32767, 1000, 0);
        add_op(-32768, 0, 0);
        add_op(1, -1, 1);
        add_op(12345, -32767, 0);
        wait_drained();

        // Exponent of -16 with int8 saturation
        set_config(-16, 15, -16, 1'b1);
        add_op(300, 1, 0);
        add_op(-300, 5, 1);
        add_op(100, 1, 0);
        add_op(-32768, 1, 1);
        wait_drained();

        // Halfway values round to even
        set_config(0, 0, 1, 1'b0);
        add_op(1, 7, 0);
        add_op(3, 7, 0);
        add_op(-5, 7, 1);
        add_op(6, 4, 0);
        add_op(32767, -32768, 1);
        wait_drained();

        // Large upscale saturates toward the dividend sign
        set_config(0, 0, -16, 1'b0);
        add_op(1, 3, 0);
        add_op(-1, 3, 1);
        add_op(0, 3, 0);
        add_op(5, 5, 1);
        wait_drained();

        // Random phases, each under its own register setting
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: set_config(-16, -16, -16, 1'b0);
                1: set_config(15, 15, 15, 1'b1);
                2: set_config(-16, 15, 15, 1'b0);
                3: set_config(15, -16, -16, 1'b1);
                default:
                begin
                    de = random_exponent();
                    ve = random_exponent();
                    m  = (de < ve) ? de : ve;
                    if ($urandom_range(0, 3) != 0)
                    begin
                        oe = m + $urandom_range(0, 8) - 4;
                        if (oe < -16)
                            oe = -16;
                        if (oe > 15)
                            oe = 15;
                    end
                    else
                    begin
                        oe = random_exponent();
                    end
                    set_config(de, ve, oe, 1'($urandom_range(0, 1)));
                end
            endcase
            // one phase in the middle and the closing phases run without idling
            idle_enable = (p != 4) && (p < RANDOM_PHASES - 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
                pending_ops.push_back(random_operand());
            wait_drained();
        end

        repeat (2 * LATENCY) @(posedge clk);
        if (fail_count == 0 && remainder_queue.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
rtl/qefm_pkg.sv
rtl/qefm_if.sv
rtl/qefm_front.sv
rtl/qefm_cell.sv
rtl/qefm_rescale.sv
rtl/quantized_elementwise_fmod_unit.sv
sim/quantized_elementwise_fmod_unit_tb.sv
